>>> src/mhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants for the min-heap priority queue
// Entry layout, payload structs, opcodes, status codes and controller states.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    localparam int CAPACITY  = 1024;
    localparam int NODE_BITS = 16;
    localparam int DIST_BITS = 31;
    localparam int POS_BITS  = $clog2(CAPACITY + 1);
    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int W_BITS    = 16;

    localparam logic [DIST_BITS-1:0] DIST_INF = {DIST_BITS{1'b1}};

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_RELAX   = 2'd2,
        OP_RELAX_P = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef struct packed {
        logic [NODE_BITS-1:0] node;
        logic [NODE_BITS-1:0] pred;
        logic [DIST_BITS-1:0] distance;
    } entry_t;

    typedef struct packed {
        logic [1:0]           operation;
        logic [NODE_BITS-1:0] node_id;
        logic [NODE_BITS-1:0] predecessor;
        logic [DIST_BITS-1:0] distance;
        logic [W_BITS-1:0]    weight;
        logic [POS_BITS-1:0]  position;
        logic [POS_BITS-1:0]  source_position;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic                 extracted_valid;
        logic [NODE_BITS-1:0] out_node;
        logic [NODE_BITS-1:0] out_predecessor;
        logic [DIST_BITS-1:0] out_distance;
        logic [POS_BITS-1:0]  entry_count;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SRC_RD,
        S_SRC_WAIT,
        S_TGT_RD,
        S_TGT_WAIT,
        S_UP_RD,
        S_UP_WAIT,
        S_DN_RD,
        S_DN_WAIT,
        S_DN_RIGHT,
        S_DN_DECIDE,
        S_EXT_LAST,
        S_EXT_WAIT,
        S_DONE
    } state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load_in;       // latch input item
        logic rd_root;       // read position 1
        logic rd_last;       // read position count
        logic rd_src;        // read source position
        logic rd_pos;        // read current position
        logic rd_parent;     // read parent of current position
        logic rd_left;       // read left child
        logic rd_right;      // read right child
        logic cap_root;      // latch root as the extracted entry
        logic cap_cur;       // latch read data as carried entry
        logic cap_base;      // latch read data distance as base
        logic cap_left;      // latch read data as left child
        logic lower;         // lower carried entry key
        logic wr_new;        // append inserted entry, set cur to new count
        logic dec_count;     // drop count on extract
        logic up_move;       // write parent into cur, cur <= parent
        logic up_place;      // write carried entry at cur
        logic dn_move;       // write best child into cur, cur <= best
        logic dn_right;      // best child is the right one
        logic set_status;    // record status
        status_t status;
        logic out_load;      // load result register
    } dp_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic pos_bad;
        logic src_bad;
        logic lowers;       // candidate below stored distance
        logic at_root;
        logic parent_gt;    // parent dist > carried dist
        logic has_left;
        logic has_right;
        logic left_lt;      // left dist < carried dist
        logic right_best;   // right strictly smaller than current best
    } dp_stat_t;

endpackage

>>> src/min_heap_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue: binary min-heap for shortest-path search
// Insert, extract-min and two decrease-key (relax) operations on a heap of
// up to 1024 entries keyed on 31-bit distance.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one operation item per handshake (s_valid/s_ready).
//   m_ channel returns exactly one result item per operation (m_valid/m_ready).
//   One item is processed at a time; s_ready is high only while idle.
//   At full depth an insert climbs at most ten levels and an extract sinks at
//   most nine. The single-port heap memory with registered read allows one
//   access per cycle.
//   The result sits in an output register; if the receiver stalls, the next
//   operation is accepted and worked, and only its final result load waits
//   for m_ready.
//   Reset (aresetn low, synchronous) empties the heap: the entry count goes
//   to zero, no clearing pass is needed, and entries are written before read.
// ----------------------------------------------------------------------------
module min_heap_priority_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mhpq_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mhpq_pkg::out_item_t m_data
);

    mhpq_pkg::dp_cmd_t  cmd;
    mhpq_pkg::dp_stat_t stat;

    mhpq_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .stat          (stat),
        .cmd           (cmd)
    );

    mhpq_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (s_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_item (m_data)
    );

endmodule

>>> src/mhpq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_datapath: heap storage, carried entry and position registers
// Single-port heap memory with registered read, compare logic and result reg.
// ----------------------------------------------------------------------------
module mhpq_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  mhpq_pkg::in_item_t  in_item,
    input  mhpq_pkg::dp_cmd_t   cmd,
    output mhpq_pkg::dp_stat_t  stat,
    output mhpq_pkg::out_item_t out_item
);

    localparam int PB = mhpq_pkg::POS_BITS;
    localparam int DB = mhpq_pkg::DIST_BITS;

    mhpq_pkg::entry_t mem [mhpq_pkg::CAPACITY];
    mhpq_pkg::entry_t rd_data_reg;

    mhpq_pkg::in_item_t req_reg;
    mhpq_pkg::entry_t   cur_ent_reg, cur_ent_next;
    mhpq_pkg::entry_t   left_ent_reg;
    mhpq_pkg::entry_t   ext_ent_reg;
    logic [PB-1:0]      cur_pos_reg, cur_pos_next;
    logic [PB-1:0]      count_reg, count_next;
    logic [DB-1:0]      base_reg;
    logic [1:0]         status_reg;
    mhpq_pkg::out_item_t out_reg;

    logic [PB-1:0]      rd_pos, wr_pos;
    logic               rd_en, wr_en;
    mhpq_pkg::entry_t   wr_data;
    logic [PB-1:0]      parent_pos, left_pos, right_pos;
    logic [DB:0]        sum;
    logic [DB-1:0]      cand;
    logic               has_right, left_lt;

    assign parent_pos = cur_pos_reg >> 1;
    assign left_pos   = {cur_pos_reg[PB-2:0], 1'b0};
    assign right_pos  = {cur_pos_reg[PB-2:0], 1'b1};

    // Saturating candidate distance
    assign sum  = {1'b0, base_reg} + {{(DB+1-mhpq_pkg::W_BITS){1'b0}}, req_reg.weight};
    assign cand = (sum >= {1'b0, mhpq_pkg::DIST_INF}) ? mhpq_pkg::DIST_INF : sum[DB-1:0];

    // Select memory read address
    always_comb begin
        rd_en  = 1'b1;
        rd_pos = cur_pos_reg;
        if (cmd.rd_root) begin
            rd_pos = PB'(1);
        end else if (cmd.rd_last) begin
            rd_pos = count_reg;
        end else if (cmd.rd_src) begin
            rd_pos = req_reg.source_position;
        end else if (cmd.rd_parent) begin
            rd_pos = parent_pos;
        end else if (cmd.rd_left) begin
            rd_pos = left_pos;
        end else if (cmd.rd_right) begin
            rd_pos = right_pos;
        end else if (!cmd.rd_pos) begin
            rd_en = 1'b0;
        end
    end

    // Select memory write
    always_comb begin
        wr_en   = 1'b0;
        wr_pos  = cur_pos_reg;
        wr_data = cur_ent_reg;
        if (cmd.up_move) begin
            wr_en   = 1'b1;
            wr_data = rd_data_reg;
        end else if (cmd.dn_move) begin
            wr_en   = 1'b1;
            wr_data = cmd.dn_right ? rd_data_reg : left_ent_reg;
        end else if (cmd.up_place) begin
            wr_en   = 1'b1;
        end
    end

    // Heap memory, positions 1..CAPACITY at addresses 0..CAPACITY-1
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[mhpq_pkg::ADDR_BITS'(wr_pos - PB'(1))] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[mhpq_pkg::ADDR_BITS'(rd_pos - PB'(1))];
        end
    end

    // Carried entry and position
    always_comb begin
        cur_ent_next = cur_ent_reg;
        cur_pos_next = cur_pos_reg;
        count_next   = count_reg;
        if (cmd.load_in) begin
            cur_pos_next = in_item.position;
        end
        if (cmd.wr_new) begin
            cur_ent_next.node     = req_reg.node_id;
            cur_ent_next.pred     = req_reg.predecessor;
            cur_ent_next.distance = req_reg.distance;
            count_next            = count_reg + PB'(1);
            cur_pos_next          = count_reg + PB'(1);
        end
        if (cmd.dec_count) begin
            count_next   = count_reg - PB'(1);
            cur_pos_next = PB'(1);
        end
        if (cmd.cap_cur) begin
            cur_ent_next = rd_data_reg;
        end
        if (cmd.lower) begin
            cur_ent_next.distance = cand;
            cur_ent_next.pred = (req_reg.operation == mhpq_pkg::OP_RELAX_P) ?
                mhpq_pkg::NODE_BITS'(req_reg.source_position) : req_reg.predecessor;
        end
        if (cmd.up_move) begin
            cur_pos_next = parent_pos;
        end
        if (cmd.dn_move) begin
            cur_pos_next = cmd.dn_right ? right_pos : left_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            req_reg  <= in_item;
            base_reg <= in_item.distance;
        end
        if (cmd.cap_base) begin
            base_reg <= rd_data_reg.distance;
        end
        cur_ent_reg <= cur_ent_next;
        cur_pos_reg <= cur_pos_next;
        if (cmd.cap_root) begin
            ext_ent_reg <= rd_data_reg;
        end
        if (cmd.cap_left) begin
            left_ent_reg <= rd_data_reg;
        end
        if (cmd.set_status) begin
            status_reg <= cmd.status;
        end
        if (cmd.out_load) begin
            out_reg.status          <= status_reg;
            out_reg.extracted_valid <= (req_reg.operation == mhpq_pkg::OP_EXTRACT) &&
                                       (status_reg == mhpq_pkg::ST_OK);
            if ((req_reg.operation == mhpq_pkg::OP_EXTRACT) &&
                (status_reg == mhpq_pkg::ST_OK)) begin
                out_reg.out_node        <= ext_ent_reg.node;
                out_reg.out_predecessor <= ext_ent_reg.pred;
                out_reg.out_distance    <= ext_ent_reg.distance;
            end else begin
                out_reg.out_node        <= '0;
                out_reg.out_predecessor <= '0;
                out_reg.out_distance    <= '0;
            end
            out_reg.entry_count <= count_reg;
        end
    end

    // Child compares for sift down
    assign has_right = (({1'b0, cur_pos_reg} << 1) + (PB+1)'(1)) <= {1'b0, count_reg};
    assign left_lt   = (left_ent_reg.distance < cur_ent_reg.distance);

    // Status toward controller
    always_comb begin
        stat.op         = mhpq_pkg::op_t'(req_reg.operation);
        stat.full       = (count_reg >= PB'(mhpq_pkg::CAPACITY));
        stat.empty      = (count_reg == '0);
        stat.pos_bad    = (req_reg.position == '0) || (req_reg.position > count_reg);
        stat.src_bad    = (req_reg.source_position == '0) ||
                          (req_reg.source_position > count_reg);
        stat.lowers     = (cur_ent_reg.distance > cand);
        stat.at_root    = (cur_pos_reg <= PB'(1));
        stat.parent_gt  = (rd_data_reg.distance > cur_ent_reg.distance);
        stat.has_left   = ({1'b0, cur_pos_reg} << 1) <= {1'b0, count_reg};
        stat.has_right  = has_right;
        stat.left_lt    = left_lt;
        // right wins only when strictly below the better of carried and left
        stat.right_best = has_right && (rd_data_reg.distance <
            (left_lt ? left_ent_reg.distance : cur_ent_reg.distance));
    end

    assign out_item = out_reg;

endmodule

>>> src/mhpq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_ctrl: operation sequencer for the min-heap
// Walks validation, key lowering, sift up and sift down one level at a time.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  mhpq_pkg::dp_stat_t stat,
    output mhpq_pkg::dp_cmd_t  cmd
);

    mhpq_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mhpq_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd           = '0;
        cmd.status    = mhpq_pkg::ST_OK;
        s_ready       = 1'b0;
        case (state_reg)
            mhpq_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = mhpq_pkg::S_DECODE;
                end
            end
            mhpq_pkg::S_DECODE: begin
                cmd.set_status = 1'b1;
                case (stat.op)
                    mhpq_pkg::OP_INSERT: begin
                        if (stat.full) begin
                            cmd.status = mhpq_pkg::ST_FULL;
                            state_next = mhpq_pkg::S_DONE;
                        end else begin
                            cmd.wr_new = 1'b1;
                            state_next = mhpq_pkg::S_UP_RD;
                        end
                    end
                    mhpq_pkg::OP_EXTRACT: begin
                        if (stat.empty) begin
                            cmd.status = mhpq_pkg::ST_EMPTY;
                            state_next = mhpq_pkg::S_DONE;
                        end else begin
                            cmd.rd_root = 1'b1;
                            state_next  = mhpq_pkg::S_EXT_LAST;
                        end
                    end
                    mhpq_pkg::OP_RELAX: begin
                        if (stat.pos_bad) begin
                            cmd.status = mhpq_pkg::ST_BADPOS;
                            state_next = mhpq_pkg::S_DONE;
                        end else begin
                            state_next = mhpq_pkg::S_TGT_RD;
                        end
                    end
                    default: begin
                        if (stat.pos_bad || stat.src_bad) begin
                            cmd.status = mhpq_pkg::ST_BADPOS;
                            state_next = mhpq_pkg::S_DONE;
                        end else begin
                            state_next = mhpq_pkg::S_SRC_RD;
                        end
                    end
                endcase
            end
            mhpq_pkg::S_SRC_RD: begin
                cmd.rd_src = 1'b1;
                state_next = mhpq_pkg::S_SRC_WAIT;
            end
            mhpq_pkg::S_SRC_WAIT: begin
                cmd.cap_base = 1'b1;
                state_next   = mhpq_pkg::S_TGT_RD;
            end
            mhpq_pkg::S_TGT_RD: begin
                cmd.rd_pos = 1'b1;
                state_next = mhpq_pkg::S_TGT_WAIT;
            end
            mhpq_pkg::S_TGT_WAIT: begin
                cmd.cap_cur = 1'b1;
                state_next  = mhpq_pkg::S_DN_DECIDE;
            end
            mhpq_pkg::S_DN_DECIDE: begin
                // lower check for relax (carried entry now valid)
                if (stat.lowers) begin
                    cmd.lower  = 1'b1;
                    state_next = mhpq_pkg::S_UP_RD;
                end else begin
                    state_next = mhpq_pkg::S_DONE;
                end
            end
            mhpq_pkg::S_EXT_LAST: begin
                cmd.cap_root = 1'b1;
                cmd.rd_last  = 1'b1;
                state_next   = mhpq_pkg::S_EXT_WAIT;
            end
            mhpq_pkg::S_EXT_WAIT: begin
                cmd.cap_cur   = 1'b1;
                cmd.dec_count = 1'b1;
                state_next    = mhpq_pkg::S_DN_RD;
            end
            mhpq_pkg::S_UP_RD: begin
                if (stat.at_root) begin
                    cmd.up_place = 1'b1;
                    state_next   = mhpq_pkg::S_DONE;
                end else begin
                    cmd.rd_parent = 1'b1;
                    state_next    = mhpq_pkg::S_UP_WAIT;
                end
            end
            mhpq_pkg::S_UP_WAIT: begin
                if (stat.parent_gt) begin
                    cmd.up_move = 1'b1;
                    state_next  = mhpq_pkg::S_UP_RD;
                end else begin
                    cmd.up_place = 1'b1;
                    state_next   = mhpq_pkg::S_DONE;
                end
            end
            mhpq_pkg::S_DN_RD: begin
                if (stat.has_left) begin
                    cmd.rd_left = 1'b1;
                    state_next  = mhpq_pkg::S_DN_WAIT;
                end else begin
                    cmd.up_place = 1'b1;
                    state_next   = mhpq_pkg::S_DONE;
                end
            end
            mhpq_pkg::S_DN_WAIT: begin
                cmd.cap_left = 1'b1;
                if (stat.has_right) begin
                    cmd.rd_right = 1'b1;
                end
                state_next = mhpq_pkg::S_DN_RIGHT;
            end
            mhpq_pkg::S_DN_RIGHT: begin
                // read data holds right child when present, else left child
                if (stat.has_right && stat.right_best) begin
                    cmd.dn_right = 1'b1;
                    cmd.dn_move  = 1'b1;
                    state_next   = mhpq_pkg::S_DN_RD;
                end else if (stat.left_lt) begin
                    // left child is in left_ent register; move it
                    cmd.dn_move = 1'b1;
                    state_next  = mhpq_pkg::S_DN_RD;
                end else begin
                    cmd.up_place = 1'b1;
                    state_next   = mhpq_pkg::S_DONE;
                end
            end
            mhpq_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = mhpq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mhpq_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == mhpq_pkg::S_IDLE)
        else $error("ready outside idle");
    a_load_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |-> s_valid && s_ready)
        else $error("load without accept");
    a_out_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result not presented");
`endif

endmodule
